[rtl/dmrp_pkg.sv]
// Shared types, constants and register map of the dual motor ramp PWM unit.
package dmrp_pkg;

  localparam int DUTY_WIDTH_DEF = 16;

  localparam int SPEED_W = 8;
  localparam int MAG_W   = 7;
  localparam int VOLT_W  = 16;
  localparam int STEP_W  = 7;
  localparam int DUTY_W  = 16;
  localparam int P1_W    = MAG_W + VOLT_W;
  localparam int NUM_W   = P1_W + VOLT_W;
  localparam int DEN_W   = VOLT_W + MAG_W;
  localparam int CNT_W   = $clog2(NUM_W + 1);

  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam int PCT_FULL  = 100;
  localparam int VOLT_MIN  = 300;

  localparam logic [VOLT_W-1:0] NOMINAL_RST  = 16'd820;
  localparam logic [VOLT_W-1:0] PERIOD_RST   = 16'd999;
  localparam logic [STEP_W-1:0] RAMP_RST     = 7'd10;
  localparam logic [STEP_W-1:0] DEADBAND_RST = 7'd25;
  localparam logic [VOLT_W-1:0] SUPPLY_RST   = 16'd820;

  localparam logic [1:0] REG_NOMINAL  = 2'd0;
  localparam logic [1:0] REG_PERIOD   = 2'd1;
  localparam logic [1:0] REG_RAMP     = 2'd2;
  localparam logic [1:0] REG_DEADBAND = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_FIN
  } state_e;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic [VOLT_W-1:0] nominal;
    logic [VOLT_W-1:0] period;
    logic [STEP_W-1:0] ramp;
    logic [STEP_W-1:0] deadband;
  } cfg_t;

endpackage

[rtl/dmrp_lane.sv]
// One motor lane: magnitude products, restoring divider and duty cap.
module dmrp_lane #(
  parameter int DUTY_WIDTH = dmrp_pkg::DUTY_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  dmrp_pkg::cmd_t                     cmd_i,
  input  dmrp_pkg::cfg_t                     cfg_i,
  input  logic        [dmrp_pkg::VOLT_W-1:0] supply_i,
  input  logic signed [dmrp_pkg::SPEED_W-1:0] speed_i,
  output logic        [dmrp_pkg::DUTY_W-1:0] duty_o
);

  localparam int P1_W  = dmrp_pkg::P1_W;
  localparam int NUM_W = dmrp_pkg::NUM_W;
  localparam int DEN_W = dmrp_pkg::DEN_W;
  localparam logic [32:0] DUTY_LIM = (33'd1 << DUTY_WIDTH) - 33'd1;

  logic [dmrp_pkg::SPEED_W-1:0] abs_speed;
  logic [dmrp_pkg::MAG_W-1:0]   mag;
  logic [P1_W-1:0]              p1_d, p1_q;
  logic [NUM_W-1:0]             num_d, num_q;
  logic [DEN_W-1:0]             den_d, den_q;
  logic [DEN_W-1:0]             rem_d, rem_q;
  logic [DEN_W:0]               rem_sh;
  logic                         fits;
  logic [NUM_W-1:0]             capped;
  logic [32:0]                  limited;

  assign abs_speed = speed_i[dmrp_pkg::SPEED_W-1] ? dmrp_pkg::SPEED_W'(-speed_i)
                                                   : speed_i;
  assign mag       = abs_speed[dmrp_pkg::MAG_W-1:0];
  assign rem_sh    = {rem_q, num_q[NUM_W-1]};
  assign fits      = rem_sh >= {1'b0, den_q};

  always_comb begin
    p1_d  = p1_q;
    num_d = num_q;
    den_d = den_q;
    rem_d = rem_q;
    if (cmd_i.mul1) begin
      p1_d = P1_W'(mag) * P1_W'(cfg_i.period);
    end
    if (cmd_i.mul2) begin
      rem_d = '0;
      if (cfg_i.nominal != '0) begin
        num_d = NUM_W'(p1_q) * NUM_W'(cfg_i.nominal);
        den_d = DEN_W'(supply_i) * DEN_W'(dmrp_pkg::PCT_FULL);
      end else begin
        num_d = NUM_W'(p1_q);
        den_d = DEN_W'(dmrp_pkg::PCT_FULL);
      end
    end
    if (cmd_i.step) begin
      if (fits) begin
        rem_d = DEN_W'(rem_sh - {1'b0, den_q});
        num_d = {num_q[NUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DEN_W-1:0];
        num_d = {num_q[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q  <= p1_d;
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  always_comb begin
    capped  = (num_q > NUM_W'(cfg_i.period)) ? NUM_W'(cfg_i.period) : num_q;
    limited = (33'(capped) > DUTY_LIM) ? DUTY_LIM : 33'(capped);
    duty_o  = limited[dmrp_pkg::DUTY_W-1:0];
  end

endmodule

[rtl/dmrp_datapath.sv]
// Datapath: speed ramps, supply register, two duty lanes and result registers.
module dmrp_datapath #(
  parameter int DUTY_WIDTH = dmrp_pkg::DUTY_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dmrp_pkg::cmd_t                      cmd_i,
  input  dmrp_pkg::cfg_t                      cfg_i,
  input  logic signed [dmrp_pkg::SPEED_W-1:0] target_left_i,
  input  logic signed [dmrp_pkg::SPEED_W-1:0] target_right_i,
  input  logic                                voltage_update_i,
  input  logic        [dmrp_pkg::VOLT_W-1:0]  battery_voltage_i,
  output logic        [dmrp_pkg::DUTY_W-1:0]  left_forward_duty_o,
  output logic        [dmrp_pkg::DUTY_W-1:0]  left_backward_duty_o,
  output logic        [dmrp_pkg::DUTY_W-1:0]  right_forward_duty_o,
  output logic        [dmrp_pkg::DUTY_W-1:0]  right_backward_duty_o,
  output logic signed [dmrp_pkg::SPEED_W-1:0] left_speed_now_o,
  output logic signed [dmrp_pkg::SPEED_W-1:0] right_speed_now_o
);

  localparam int SW = dmrp_pkg::SPEED_W;

  function automatic logic signed [SW-1:0] sat_target(input logic signed [SW-1:0] raw);
    logic signed [SW-1:0] v;
    v = raw;
    if (raw > SW'(dmrp_pkg::PCT_FULL)) v = SW'(dmrp_pkg::PCT_FULL);
    if (raw < -SW'(dmrp_pkg::PCT_FULL)) v = -SW'(dmrp_pkg::PCT_FULL);
    return v;
  endfunction

  function automatic logic signed [SW-1:0] ramp(
    input logic signed [SW-1:0]             cur,
    input logic signed [SW-1:0]             tgt,
    input logic [dmrp_pkg::STEP_W-1:0]      step,
    input logic [dmrp_pkg::STEP_W-1:0]      db
  );
    logic signed [9:0] c, t, s, d, n;
    c = 10'(cur);
    t = 10'(tgt);
    s = {3'b000, step};
    d = {3'b000, db};
    if (t == 0 || (t > 0 && t < c) || (t < 0 && t > c)) begin
      n = t;
    end else if ((t > 0 && c < 0) || (t < 0 && c > 0)) begin
      n = '0;
    end else if (t > c) begin
      if (c == 0 && t >= d) n = d;
      else n = c + s;
      if (n > t) n = t;
    end else if (t < c) begin
      if (c == 0 && t <= -d) n = -d;
      else n = c - s;
      if (n < t) n = t;
    end else begin
      n = c;
    end
    return n[SW-1:0];
  endfunction

  logic signed [SW-1:0]               left_speed_d, left_speed_q;
  logic signed [SW-1:0]               right_speed_d, right_speed_q;
  logic [dmrp_pkg::VOLT_W-1:0]        supply_d, supply_q;
  logic [dmrp_pkg::DUTY_W-1:0]        left_duty, right_duty;

  always_comb begin
    left_speed_d  = left_speed_q;
    right_speed_d = right_speed_q;
    supply_d      = supply_q;
    if (cmd_i.load) begin
      left_speed_d  = ramp(left_speed_q, sat_target(target_left_i), cfg_i.ramp,
                           cfg_i.deadband);
      right_speed_d = ramp(right_speed_q, sat_target(target_right_i), cfg_i.ramp,
                           cfg_i.deadband);
      if (voltage_update_i &&
          battery_voltage_i >= dmrp_pkg::VOLT_W'(dmrp_pkg::VOLT_MIN)) begin
        supply_d = battery_voltage_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_speed_q  <= '0;
      right_speed_q <= '0;
      supply_q      <= dmrp_pkg::SUPPLY_RST;
    end else begin
      left_speed_q  <= left_speed_d;
      right_speed_q <= right_speed_d;
      supply_q      <= supply_d;
    end
  end

  dmrp_lane #(.DUTY_WIDTH(DUTY_WIDTH)) u_lane_left (
    .clk_i    (clk_i),
    .cmd_i    (cmd_i),
    .cfg_i    (cfg_i),
    .supply_i (supply_q),
    .speed_i  (left_speed_q),
    .duty_o   (left_duty)
  );

  dmrp_lane #(.DUTY_WIDTH(DUTY_WIDTH)) u_lane_right (
    .clk_i    (clk_i),
    .cmd_i    (cmd_i),
    .cfg_i    (cfg_i),
    .supply_i (supply_q),
    .speed_i  (right_speed_q),
    .duty_o   (right_duty)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      left_forward_duty_o   <= (left_speed_q > 0) ? left_duty : '0;
      left_backward_duty_o  <= (left_speed_q < 0) ? left_duty : '0;
      right_forward_duty_o  <= (right_speed_q > 0) ? right_duty : '0;
      right_backward_duty_o <= (right_speed_q < 0) ? right_duty : '0;
      left_speed_now_o      <= left_speed_q;
      right_speed_now_o     <= right_speed_q;
    end
  end

endmodule

[rtl/dmrp_ctrl.sv]
// Controller: sequences ramp load, products, divide steps and result hand-off.
module dmrp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dmrp_pkg::cmd_t cmd_o
);

  localparam int CNT_W = dmrp_pkg::CNT_W;

  dmrp_pkg::state_e state_d, state_q;
  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic             out_valid_d, out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dmrp_pkg::S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      dmrp_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = dmrp_pkg::S_MUL1;
        end
      end
      dmrp_pkg::S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = dmrp_pkg::S_MUL2;
      end
      dmrp_pkg::S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        cnt_d      = '0;
        state_d    = dmrp_pkg::S_DIV;
      end
      dmrp_pkg::S_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(dmrp_pkg::NUM_W - 1)) begin
          state_d = dmrp_pkg::S_FIN;
        end
      end
      dmrp_pkg::S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = dmrp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dmrp_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/dual_motor_ramp_pwm_compensated_unit.sv]
// Top level of the dual motor ramp unit with supply-compensated PWM duty.
// Each accepted request updates both ramped speeds in its accept cycle, and
// the supply reading too when an update is flagged at or above the minimum;
// it then forms the duty products in the MUL1 and MUL2 states and runs one
// 39-bit restoring divider per motor, side by side, one quotient bit per cycle;
// the FIN state then moves the result into the output register. The next
// request is taken only once the unit is back in idle, while an earlier
// result may still wait in the output register; a result still stalled there
// when the next one is ready holds the unit until it is taken.
// Configuration registers sit on the APB port at byte addresses 0, 4, 8, 12.
module dual_motor_ramp_pwm_compensated_unit #(
  parameter int DUTY_WIDTH = dmrp_pkg::DUTY_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [dmrp_pkg::ADDR_W-1:0]         paddr,
  input  logic [dmrp_pkg::DATA_W-1:0]         pwdata,
  output logic [dmrp_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [dmrp_pkg::SPEED_W-1:0] target_left_i,
  input  logic signed [dmrp_pkg::SPEED_W-1:0] target_right_i,
  input  logic                                voltage_update_i,
  input  logic        [dmrp_pkg::VOLT_W-1:0]  battery_voltage_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [dmrp_pkg::DUTY_W-1:0]  left_forward_duty_o,
  output logic        [dmrp_pkg::DUTY_W-1:0]  left_backward_duty_o,
  output logic        [dmrp_pkg::DUTY_W-1:0]  right_forward_duty_o,
  output logic        [dmrp_pkg::DUTY_W-1:0]  right_backward_duty_o,
  output logic signed [dmrp_pkg::SPEED_W-1:0] left_speed_now_o,
  output logic signed [dmrp_pkg::SPEED_W-1:0] right_speed_now_o
);

  dmrp_pkg::cfg_t cfg_d, cfg_q;
  dmrp_pkg::cmd_t cmd;
  logic [1:0]     reg_idx;
  logic           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        dmrp_pkg::REG_NOMINAL:  cfg_d.nominal  = pwdata[dmrp_pkg::VOLT_W-1:0];
        dmrp_pkg::REG_PERIOD:   cfg_d.period   = pwdata[dmrp_pkg::VOLT_W-1:0];
        dmrp_pkg::REG_RAMP:     cfg_d.ramp     = pwdata[dmrp_pkg::STEP_W-1:0];
        dmrp_pkg::REG_DEADBAND: cfg_d.deadband = pwdata[dmrp_pkg::STEP_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.nominal  <= dmrp_pkg::NOMINAL_RST;
      cfg_q.period   <= dmrp_pkg::PERIOD_RST;
      cfg_q.ramp     <= dmrp_pkg::RAMP_RST;
      cfg_q.deadband <= dmrp_pkg::DEADBAND_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (reg_idx)
      dmrp_pkg::REG_NOMINAL:  prdata = dmrp_pkg::DATA_W'(cfg_q.nominal);
      dmrp_pkg::REG_PERIOD:   prdata = dmrp_pkg::DATA_W'(cfg_q.period);
      dmrp_pkg::REG_RAMP:     prdata = dmrp_pkg::DATA_W'(cfg_q.ramp);
      dmrp_pkg::REG_DEADBAND: prdata = dmrp_pkg::DATA_W'(cfg_q.deadband);
      default:                prdata = '0;
    endcase
  end

  dmrp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  dmrp_datapath #(.DUTY_WIDTH(DUTY_WIDTH)) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .cfg_i                 (cfg_q),
    .target_left_i         (target_left_i),
    .target_right_i        (target_right_i),
    .voltage_update_i      (voltage_update_i),
    .battery_voltage_i     (battery_voltage_i),
    .left_forward_duty_o   (left_forward_duty_o),
    .left_backward_duty_o  (left_backward_duty_o),
    .right_forward_duty_o  (right_forward_duty_o),
    .right_backward_duty_o (right_backward_duty_o),
    .left_speed_now_o      (left_speed_now_o),
    .right_speed_now_o     (right_speed_now_o)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while previous one still in progress");

  a_left_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_forward_duty_o == '0 || left_backward_duty_o == '0))
    else $error("left motor driven in both directions");

  a_right_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (right_forward_duty_o == '0 || right_backward_duty_o == '0))
    else $error("right motor driven in both directions");

  a_stopped_no_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && left_speed_now_o == '0) |->
      (left_forward_duty_o == '0 && left_backward_duty_o == '0))
    else $error("left duty non-zero at standstill");

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the dual motor ramp unit with compensated PWM duty.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dmrp_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] tgt_l;
    logic signed [SPEED_W-1:0] tgt_r;
    logic                      vupd;
    logic [VOLT_W-1:0]         vbat;
  } tick_request_t;

  typedef struct packed {
    logic [DUTY_W-1:0]         lf;
    logic [DUTY_W-1:0]         lb;
    logic [DUTY_W-1:0]         rf;
    logic [DUTY_W-1:0]         rb;
    logic signed [SPEED_W-1:0] ls;
    logic signed [SPEED_W-1:0] rs;
  } duty_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic signed [SPEED_W-1:0] target_left_i = '0;
  logic signed [SPEED_W-1:0] target_right_i = '0;
  logic                      voltage_update_i = 1'b0;
  logic [VOLT_W-1:0]         battery_voltage_i = '0;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [DUTY_W-1:0]         left_forward_duty_o;
  logic [DUTY_W-1:0]         left_backward_duty_o;
  logic [DUTY_W-1:0]         right_forward_duty_o;
  logic [DUTY_W-1:0]         right_backward_duty_o;
  logic signed [SPEED_W-1:0] left_speed_now_o;
  logic signed [SPEED_W-1:0] right_speed_now_o;

  dual_motor_ramp_pwm_compensated_unit dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .target_left_i         (target_left_i),
    .target_right_i        (target_right_i),
    .voltage_update_i      (voltage_update_i),
    .battery_voltage_i     (battery_voltage_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .left_forward_duty_o   (left_forward_duty_o),
    .left_backward_duty_o  (left_backward_duty_o),
    .right_forward_duty_o  (right_forward_duty_o),
    .right_backward_duty_o (right_backward_duty_o),
    .left_speed_now_o      (left_speed_now_o),
    .right_speed_now_o     (right_speed_now_o)
  );

  always #6ns clk_i = ~clk_i;

  // Predictor state and register shadow
  logic [VOLT_W-1:0] cfg_nominal  = NOMINAL_RST;
  logic [VOLT_W-1:0] cfg_period   = PERIOD_RST;
  int                cfg_ramp     = int'(RAMP_RST);
  int                cfg_deadband = int'(DEADBAND_RST);
  int                speed_l      = 0;
  int                speed_r      = 0;
  logic [VOLT_W-1:0] supply_volts = SUPPLY_RST;

  tick_request_t pending_requests[$];
  duty_result_t  duty_expected[$];

  int  n_queued = 0;
  int  n_accepted = 0;
  int  n_checked = 0;
  int  n_failures = 0;
  int  n_settings = 0;
  bit  quiet = 1'b0;
  bit  req_taken = 1'b0;
  int  in_gap = 0;
  int  out_hold = 0;

  function automatic int sat_pct(logic signed [SPEED_W-1:0] raw);
    int v;
    v = int'(raw);
    if (v > PCT_FULL) v = PCT_FULL;
    if (v < -PCT_FULL) v = -PCT_FULL;
    return v;
  endfunction

  function automatic int ramp_toward(int cur, int tgt);
    int nxt;
    nxt = cur;
    if (tgt == 0 || (tgt > 0 && tgt < cur) || (tgt < 0 && tgt > cur)) return tgt;
    if ((tgt > 0 && cur < 0) || (tgt < 0 && cur > 0)) return 0;
    if (tgt > cur) begin
      if (cur == 0 && tgt >= cfg_deadband) nxt = cfg_deadband;
      else nxt = cur + cfg_ramp;
      if (nxt > tgt) nxt = tgt;
    end else if (tgt < cur) begin
      if (cur == 0 && tgt <= -cfg_deadband) nxt = -cfg_deadband;
      else nxt = cur - cfg_ramp;
      if (nxt < tgt) nxt = tgt;
    end
    return nxt;
  endfunction

  function automatic logic [DUTY_W-1:0] duty_for_speed(int spd);
    u64_t mag;
    u64_t d;
    mag = u64_t'(spd < 0 ? -spd : spd);
    if (cfg_nominal != 0)
      d = (mag * u64_t'(cfg_period) * u64_t'(cfg_nominal)) /
          (u64_t'(PCT_FULL) * u64_t'(supply_volts));
    else
      d = (mag * u64_t'(cfg_period)) / u64_t'(PCT_FULL);
    if (d > u64_t'(cfg_period)) d = u64_t'(cfg_period);
    return d[DUTY_W-1:0];
  endfunction

  task automatic note_field(string field, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      n_failures++;
      if (n_failures <= 10)
        $display("mismatch on %s: expected %0d, got %0d (result %0d)",
                 field, exp_v, act_v, n_checked);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    duty_result_t got;
    duty_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{left_forward_duty_o, left_backward_duty_o, right_forward_duty_o,
                right_backward_duty_o, left_speed_now_o, right_speed_now_o};
        if (duty_expected.size() == 0) begin
          n_failures++;
          if (n_failures <= 10)
            $display("unexpected result: lf %0d lb %0d rf %0d rb %0d ls %0d rs %0d",
                     got.lf, got.lb, got.rf, got.rb, got.ls, got.rs);
        end else begin
          want = duty_expected.pop_front();
          note_field("left_forward_duty", want.lf, got.lf);
          note_field("left_backward_duty", want.lb, got.lb);
          note_field("right_forward_duty", want.rf, got.rf);
          note_field("right_backward_duty", want.rb, got.rb);
          note_field("left_speed_now", want.ls, got.ls);
          note_field("right_speed_now", want.rs, got.rs);
          n_checked++;
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (voltage_update_i && battery_voltage_i >= VOLT_MIN) supply_volts = battery_voltage_i;
        speed_l = ramp_toward(speed_l, sat_pct(target_left_i));
        speed_r = ramp_toward(speed_r, sat_pct(target_right_i));
        want.lf = speed_l > 0 ? duty_for_speed(speed_l) : '0;
        want.lb = speed_l < 0 ? duty_for_speed(speed_l) : '0;
        want.rf = speed_r > 0 ? duty_for_speed(speed_r) : '0;
        want.rb = speed_r < 0 ? duty_for_speed(speed_r) : '0;
        want.ls = speed_l[SPEED_W-1:0];
        want.rs = speed_r[SPEED_W-1:0];
        duty_expected.push_back(want);
        n_accepted++;
      end
    end
    req_taken <= rst_ni && in_valid_i && !in_stall_o;
  end

  always @(negedge clk_i) begin : driver
    tick_request_t r;
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          r = pending_requests.pop_front();
          target_left_i <= r.tgt_l;
          target_right_i <= r.tgt_r;
          voltage_update_i <= r.vupd;
          battery_voltage_i <= r.vbat;
          in_valid_i <= 1'b1;
          if (!quiet && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 12);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      if (out_hold > 0) begin
        out_stall_i <= 1'b1;
        out_hold <= out_hold - 1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        out_stall_i <= 1'b1;
        out_hold <= $urandom_range(0, 11);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic queue_tick(int tl, int tr, bit vu, int unsigned bv);
    tick_request_t r;
    r.tgt_l = tl[SPEED_W-1:0];
    r.tgt_r = tr[SPEED_W-1:0];
    r.vupd = vu;
    r.vbat = bv[VOLT_W-1:0];
    pending_requests.push_back(r);
    n_queued++;
  endtask

  task automatic set_register(logic [1:0] idx, int unsigned val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_NOMINAL:  cfg_nominal = val[VOLT_W-1:0];
      REG_PERIOD:   cfg_period = val[VOLT_W-1:0];
      REG_RAMP:     cfg_ramp = int'(val[STEP_W-1:0]);
      REG_DEADBAND: cfg_deadband = int'(val[STEP_W-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    note_field("register readback", longint'(val), longint'(prdata));
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain;
    while (n_accepted != n_queued || duty_expected.size() != 0) @(posedge clk_i);
  endtask

  function automatic int next_target(int prev);
    if ($urandom_range(0, 2) != 0) return prev;
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return int'($urandom_range(0, 255));
      2:       return PCT_FULL;
      3:       return -PCT_FULL;
      default: return int'($urandom_range(0, 2 * PCT_FULL)) - PCT_FULL;
    endcase
  endfunction

  initial begin : sequencer
    int tl;
    int tr;
    int unsigned bv;
    int unsigned plan [8][4];
    plan = '{'{820, 999, 10, 25}, '{0, 999, 7, 30}, '{65535, 65535, 127, 0},
             '{1, 65535, 0, 40}, '{1200, 0, 1, 127}, '{0, 0, 0, 0}, '{0, 0, 0, 0},
             '{820, 999, 10, 25}};
    tl = 0;
    tr = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // deadband jump, saturation, slow-down, reversal, sub-deadband start, stop, supply updates
    queue_tick(127, -128, 1'b0, 0);
    queue_tick(127, -128, 1'b0, 0);
    queue_tick(50, -20, 1'b0, 0);
    queue_tick(-100, 100, 1'b0, 0);
    queue_tick(10, -10, 1'b0, 0);
    queue_tick(0, 0, 1'b0, 0);
    queue_tick(1, -1, 1'b0, 65535);
    queue_tick(100, -100, 1'b1, 299);
    queue_tick(100, -100, 1'b1, 0);
    queue_tick(100, -100, 1'b1, 300);
    queue_tick(100, -100, 1'b1, 65535);
    queue_tick(100, -100, 1'b0, 300);
    queue_tick(100, -100, 1'b1, 820);
    for (int i = 0; i < 8; i++) queue_tick(100, -100, 1'b0, 0);
    queue_tick(-128, 127, 1'b0, 0);
    queue_tick(-26, 26, 1'b0, 0);
    queue_tick(-26, 24, 1'b0, 0);
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p == 5 || p == 6) begin
        plan[p][0] = $urandom_range(0, 65535);
        plan[p][1] = $urandom_range(0, 65535);
        plan[p][2] = $urandom_range(0, 127);
        plan[p][3] = $urandom_range(0, 127);
      end
      set_register(REG_NOMINAL, plan[p][0]);
      set_register(REG_PERIOD, plan[p][1]);
      set_register(REG_RAMP, plan[p][2]);
      set_register(REG_DEADBAND, plan[p][3]);
      n_settings++;
      quiet = (p == 7);
      for (int i = 0; i < 128; i++) begin
        tl = next_target(tl);
        tr = next_target(tr);
        case ($urandom_range(0, 3))
          0:       bv = $urandom_range(0, VOLT_MIN - 1);
          1:       bv = $urandom_range(600, 1300);
          default: bv = $urandom_range(0, 65535);
        endcase
        queue_tick(tl, tr, $urandom_range(0, 3) == 0, bv);
      end
      drain();
    end

    repeat (60) @(posedge clk_i);
    if (duty_expected.size() != 0) n_failures++;
    $display("summary: %0d requests over %0d register settings, %0d results compared",
             n_queued, n_settings + 1, n_checked);
    $display("summary: %0d failures", n_failures);
    if (n_failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #9600us;
    $display("tb: failure");
    $finish;
  end

endmodule
